@@ src/mkdh_pkg.sv @@
package mkdh_pkg;

	localparam int CNT_W     = 10;
	localparam int LEVEL_W   = 4;
	localparam int KEY_W     = 2;
	localparam int KEYS_ADDR = 2 ** KEY_W;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 2;

	localparam int NUM_KEYS_DEF = 4;

	localparam logic [CNT_W-1:0] PRESS_DB_RST    = CNT_W'(20);
	localparam logic [CNT_W-1:0] RELEASE_DB_RST  = CNT_W'(20);
	localparam logic [CNT_W-1:0] PRESCALE_RST    = CNT_W'(100);
	localparam logic [CNT_W-1:0] MAX_HOLD_RST    = CNT_W'(1023);

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESS_DB   = 2'd0,
		CFG_RELEASE_DB = 2'd1,
		CFG_PRESCALE   = 2'd2,
		CFG_MAX_HOLD   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] press_db;
		logic [CNT_W-1:0] release_db;
		logic [CNT_W-1:0] prescale;
		logic [CNT_W-1:0] max_hold;
	} cfg_t;

endpackage

@@ src/mkdh_key.sv @@
module mkdh_key (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tick,
	input  logic                        down,
	input  logic                        hold_step,
	input  mkdh_pkg::cfg_t              cfg,
	output logic                        confirm,
	output logic [mkdh_pkg::CNT_W-1:0]  hold_count
);
	import mkdh_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'b0001,
		PH_PRESS_DB   = 4'b0010,
		PH_HELD       = 4'b0100,
		PH_RELEASE_DB = 4'b1000
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] dbc_q, dbc_d;
	logic [CNT_W-1:0] hold_q, hold_d;

	always_comb begin
		phase_d = phase_q;
		dbc_d   = dbc_q;
		confirm = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (down) begin
					dbc_d   = cfg.press_db;
					phase_d = PH_PRESS_DB;
				end
			end
			PH_PRESS_DB: begin
				if (!down) begin
					phase_d = PH_IDLE;
				end else if (dbc_q != '0) begin
					dbc_d = dbc_q - 1'b1;
				end else begin
					confirm = tick;
					phase_d = PH_HELD;
				end
			end
			PH_HELD: begin
				if (!down) begin
					dbc_d   = cfg.release_db;
					phase_d = PH_RELEASE_DB;
				end
			end
			PH_RELEASE_DB: begin
				if (down) begin
					phase_d = PH_HELD;
				end else if (dbc_q != '0) begin
					dbc_d = dbc_q - 1'b1;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// count stays zero outside the held phase, so entering held starts from zero
		if (phase_d == PH_HELD) begin
			hold_d = hold_q;
			if (hold_step && (hold_q < cfg.max_hold))
				hold_d = hold_q + 1'b1;
		end else begin
			hold_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dbc_q   <= '0;
			hold_q  <= '0;
		end else if (tick) begin
			phase_q <= phase_d;
			dbc_q   <= dbc_d;
			hold_q  <= hold_d;
		end
	end

	assign hold_count = hold_q;

endmodule

@@ src/multi_key_debounce_hold_timer_unit.sv @@
// Path: an accepted request waits in the input register, then its result is loaded into
// the result register, from which the receiver takes it.
// Throughput: one request per cycle; every tick, read or query is done in a single pass.
// A stalled result holds; one more request can wait in the input register, then in_stall rises.
// Reset: arst_n clears all key phases, counters, the pending event and the pipeline
// valids at once, and loads the register defaults (20, 20, 100, 1023).
module multi_key_debounce_hold_timer_unit #(
	parameter int NUM_KEYS = mkdh_pkg::NUM_KEYS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mkdh_pkg::OP_W-1:0]      op,
	input  logic [mkdh_pkg::LEVEL_W-1:0]   key_levels,
	input  logic [mkdh_pkg::KEY_W-1:0]     key_index,
	input  logic [mkdh_pkg::CNT_W-1:0]     min_hold,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           event_valid,
	output logic [mkdh_pkg::KEY_W-1:0]     event_key,
	output logic                           held_enough,
	// register write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mkdh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mkdh_pkg::CNT_W-1:0]     cfg_data
);
	import mkdh_pkg::*;

	// queries can only address the first KEYS_ADDR keys
	localparam int QK = (NUM_KEYS < KEYS_ADDR) ? NUM_KEYS : KEYS_ADDR;

	// configuration registers
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_db   <= PRESS_DB_RST;
			cfg_q.release_db <= RELEASE_DB_RST;
			cfg_q.prescale   <= PRESCALE_RST;
			cfg_q.max_hold   <= MAX_HOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PRESS_DB:   cfg_q.press_db   <= cfg_data;
				CFG_RELEASE_DB: cfg_q.release_db <= cfg_data;
				CFG_PRESCALE:   cfg_q.prescale   <= cfg_data;
				CFG_MAX_HOLD:   cfg_q.max_hold   <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control: stage 1 holds the request, stage 2 the result
	logic valid_s1, valid_s2, out_free, fire_s1;

	assign out_free = !valid_s2 || !out_stall;
	assign fire_s1  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	logic [OP_W-1:0]    op_s1;
	logic [LEVEL_W-1:0] levels_s1;
	logic [KEY_W-1:0]   kidx_s1;
	logic [CNT_W-1:0]   minh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload holds while stalled
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1     <= op;
			levels_s1 <= key_levels;
			kidx_s1   <= key_index;
			minh_s1   <= min_hold;
		end
	end

	logic tick, rd;

	assign tick = fire_s1 && (op_s1 == OP_TICK);
	assign rd   = fire_s1 && (op_s1 == OP_READ);

	// shared prescaler: count down, reload at zero; held keys advance when it lands on zero
	logic [CNT_W-1:0] pre_q, pre_d;
	logic             hold_step;

	assign pre_d     = (pre_q != '0) ? (pre_q - 1'b1) : cfg_q.prescale;
	assign hold_step = (pre_d == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q <= '0;
		end else if (tick) begin
			pre_q <= pre_d;
		end
	end

	// per-key debouncers, all stepped in parallel on a tick
	logic [NUM_KEYS-1:0] confirm;
	logic [CNT_W-1:0]    hold_cnt [NUM_KEYS];

	for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
		logic down;
		if (g < LEVEL_W) begin : g_lvl
			assign down = levels_s1[g];
		end else begin : g_nolvl
			// keys beyond the level field never see a press
			assign down = 1'b0;
		end

		mkdh_key u_key (
			.clk        (clk),
			.arst_n     (arst_n),
			.tick       (tick),
			.down       (down),
			.hold_step  (hold_step),
			.cfg        (cfg_q),
			.confirm    (confirm[g]),
			.hold_count (hold_cnt[g])
		);
	end

	// pending event: highest confirming index wins, a read clears it
	logic             pv_q, pv_d;
	logic [KEY_W-1:0] pk_q, pk_d;

	always_comb begin
		pv_d = pv_q;
		pk_d = pk_q;
		if (tick) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (confirm[k]) begin
					pv_d = 1'b1;
					pk_d = KEY_W'(k);
				end
			end
		end
		if (rd) begin
			pv_d = 1'b0;
			pk_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
			pk_q <= '0;
		end else begin
			pv_q <= pv_d;
			pk_q <= pk_d;
		end
	end

	// query: pick the addressed key's hold count; an absent key reads as not held
	logic             q_found;
	logic [CNT_W-1:0] q_sel;

	always_comb begin
		q_found = 1'b0;
		q_sel   = '0;
		for (int k = 0; k < QK; k++) begin
			if (kidx_s1 == KEY_W'(k)) begin
				q_found = 1'b1;
				q_sel   = hold_cnt[k];
			end
		end
	end

	logic             ev_d, he_d;
	logic [KEY_W-1:0] ek_d;

	always_comb begin
		ev_d = 1'b0;
		ek_d = '0;
		he_d = 1'b0;
		case (op_s1)
			OP_READ: begin
				ev_d = pv_q;
				ek_d = pv_q ? pk_q : '0;
			end
			OP_QUERY: begin
				he_d = q_found && (q_sel >= minh_s1);
			end
			default: ;
		endcase
	end

	// result register
	logic             ev_s2, he_s2;
	logic [KEY_W-1:0] ek_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			ev_s2 <= ev_d;
			ek_s2 <= ek_d;
			he_s2 <= he_d;
		end
	end

	assign out_valid   = valid_s2;
	assign event_valid = ev_s2;
	assign event_key   = ek_s2;
	assign held_enough = he_s2;

endmodule

@@ src/mkdh_chk.sv @@
module mkdh_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [mkdh_pkg::OP_W-1:0]      op,
	input logic [mkdh_pkg::LEVEL_W-1:0]   key_levels,
	input logic [mkdh_pkg::KEY_W-1:0]     key_index,
	input logic [mkdh_pkg::CNT_W-1:0]     min_hold,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           event_valid,
	input logic [mkdh_pkg::KEY_W-1:0]     event_key,
	input logic                           held_enough
);
	import mkdh_pkg::*;

	// a stalled request stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable({op, key_levels, key_index, min_hold}))
		else $error("request changed while stalled");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// requests back up only behind a stalled, occupied result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("request stalled without a stalled result");

	// a read and a query result never mix
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(event_valid && held_enough))
		else $error("event and hold flags both set");

	// no event key without an event
	a_key_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !event_valid) |-> (event_key == '0))
		else $error("event key set without event");

endmodule

bind multi_key_debounce_hold_timer_unit mkdh_chk u_mkdh_chk (.*);

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import mkdh_pkg::*;

	localparam int NUM_KEYS       = NUM_KEYS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASE_ITEMS    = 200;

	// op code 3 has no name in the package; the block must ignore it
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PRESS_DB,
		PH_HELD,
		PH_RELEASE_DB
	} key_phase_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [LEVEL_W-1:0] levels;
		logic [KEY_W-1:0]   key;
		logic [CNT_W-1:0]   thresh;
	} request_t;

	typedef struct packed {
		logic             ev_valid;
		logic [KEY_W-1:0] ev_key;
		logic             held;
	} answer_t;

	// DUT ports, inputs all known from time zero
	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      op         = '0;
	logic [LEVEL_W-1:0]   key_levels = '0;
	logic [KEY_W-1:0]     key_index  = '0;
	logic [CNT_W-1:0]     min_hold   = '0;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic                 event_valid;
	logic [KEY_W-1:0]     event_key;
	logic                 held_enough;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CNT_W-1:0]     cfg_data   = '0;

	// keypad state as the block should hold it, reset values included
	cfg_t             kp_cfg = '{press_db: PRESS_DB_RST, release_db: RELEASE_DB_RST,
		prescale: PRESCALE_RST, max_hold: MAX_HOLD_RST};
	key_phase_t       kp_phase     [NUM_KEYS] = '{default: PH_IDLE};
	logic [CNT_W-1:0] kp_countdown [NUM_KEYS] = '{default: '0};
	logic [CNT_W-1:0] kp_hold      [NUM_KEYS] = '{default: '0};
	logic [CNT_W-1:0] kp_prescaler = '0;
	logic             kp_event_pend = 1'b0;
	logic [KEY_W-1:0] kp_event_idx  = '0;

	answer_t answer_q [$];

	// intended key levels for the random part, before bounce is added
	logic [NUM_KEYS-1:0] key_intent = '0;

	bit no_idle = 1'b0;
	int stall_run = 0;
	int stall_pick;
	int quiet_cycles = 0;
	int n_requests = 0;
	int n_results = 0;
	int n_events = 0;
	int n_settings = 0;
	int n_failures = 0;
	answer_t got_ans;
	answer_t want_ans;

	multi_key_debounce_hold_timer_unit #(
		.NUM_KEYS(NUM_KEYS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.key_levels (key_levels),
		.key_index  (key_index),
		.min_hold   (min_hold),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_valid(event_valid),
		.event_key  (event_key),
		.held_enough(held_enough),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Advance the keypad by one request and return the result it must produce.
	function automatic answer_t keypad_step(input request_t rq);
		answer_t ans;
		logic    down;
		int      k;
		ans = '0;
		case (rq.op)
			OP_TICK: begin
				// the shared prescaler steps first; held keys count on its zero
				if (kp_prescaler != '0)
					kp_prescaler = kp_prescaler - 1'b1;
				else
					kp_prescaler = kp_cfg.prescale;
				for (k = 0; k < NUM_KEYS; k++) begin
					down = rq.levels[k];
					case (kp_phase[k])
						PH_IDLE: begin
							if (down) begin
								kp_countdown[k] = kp_cfg.press_db;
								kp_phase[k]     = PH_PRESS_DB;
							end
						end
						PH_PRESS_DB: begin
							if (!down) begin
								kp_phase[k] = PH_IDLE;
							end else if (kp_countdown[k] != '0) begin
								kp_countdown[k] = kp_countdown[k] - 1'b1;
							end else begin
								// later keys overwrite, so the highest index wins
								kp_event_pend = 1'b1;
								kp_event_idx  = KEY_W'(k);
								kp_hold[k]    = '0;
								kp_phase[k]   = PH_HELD;
							end
						end
						PH_HELD: begin
							if (!down) begin
								kp_countdown[k] = kp_cfg.release_db;
								kp_phase[k]     = PH_RELEASE_DB;
							end
						end
						default: begin
							if (down)
								kp_phase[k] = PH_HELD;
							else if (kp_countdown[k] != '0)
								kp_countdown[k] = kp_countdown[k] - 1'b1;
							else
								kp_phase[k] = PH_IDLE;
						end
					endcase
					// a lowered limit freezes the count where it stands
					if (kp_phase[k] == PH_HELD) begin
						if (kp_hold[k] < kp_cfg.max_hold && kp_prescaler == '0)
							kp_hold[k] = kp_hold[k] + 1'b1;
					end else begin
						kp_hold[k] = '0;
					end
				end
			end
			OP_READ: begin
				if (kp_event_pend) begin
					ans.ev_valid = 1'b1;
					ans.ev_key   = kp_event_idx;
				end
				kp_event_pend = 1'b0;
				kp_event_idx  = '0;
			end
			OP_QUERY: begin
				if (int'(rq.key) < NUM_KEYS && kp_hold[rq.key] >= rq.thresh)
					ans.held = 1'b1;
			end
			default: ;
		endcase
		return ans;
	endfunction

	function automatic request_t pack_request(input logic [OP_W-1:0] o,
		input logic [LEVEL_W-1:0] lv, input logic [KEY_W-1:0] key,
		input logic [CNT_W-1:0] th);
		request_t rq;
		rq.op     = o;
		rq.levels = lv;
		rq.key    = key;
		rq.thresh = th;
		return rq;
	endfunction

	// Mostly short gaps, now and then a long one; none while no_idle holds.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Build one random request: mostly ticks from slowly changing key levels with
	// some bounce, so that presses get confirmed and held; the rest reads, queries
	// often near the current hold count, noise ticks and the spare op code.
	function automatic request_t make_random_request();
		request_t rq;
		int       r;
		int       k;
		int       near;
		rq.levels = LEVEL_W'($urandom_range(0, 15));
		rq.key    = KEY_W'($urandom_range(0, 3));
		rq.thresh = CNT_W'($urandom_range(0, 1023));
		r = $urandom_range(0, 99);
		if (r < 68) begin
			rq.op = OP_TICK;
			if ($urandom_range(0, 9) != 0) begin
				for (k = 0; k < NUM_KEYS; k++) begin
					if ($urandom_range(0, 99) < 6)
						key_intent[k] = ~key_intent[k];
					rq.levels[k] = key_intent[k];
					if ($urandom_range(0, 99) < 4)
						rq.levels[k] = ~rq.levels[k];
				end
			end
		end else if (r < 83) begin
			rq.op = OP_READ;
		end else if (r < 98) begin
			rq.op = OP_QUERY;
			r = $urandom_range(0, 9);
			if (r < 4) begin
				near = int'(kp_hold[rq.key]) + int'($urandom_range(0, 2)) - 1;
				if (near < 0)
					near = 0;
				if (near > 1023)
					near = 1023;
				rq.thresh = CNT_W'(near);
			end else if (r < 7) begin
				rq.thresh = CNT_W'($urandom_range(0, 4));
			end else if (r == 7) begin
				rq.thresh = '1;
			end
		end else begin
			rq.op = OP_SPARE;
		end
		return rq;
	endfunction

	// Send one request, hold it until accepted, record its expected result,
	// then idle for a random gap.
	task automatic send_request(input request_t rq);
		answer_t ans;
		int      gap;
		op         <= rq.op;
		key_levels <= rq.levels;
		key_index  <= rq.key;
		min_hold   <= rq.thresh;
		in_valid   <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		ans = keypad_step(rq);
		answer_q.push_back(ans);
		n_requests++;
		if (ans.ev_valid)
			n_events++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every expected result has come back,
	// then let the pipeline run empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers back to back; call only while the block is idle.
	task automatic load_config(input cfg_t c);
		int               i;
		cfg_idx_t         idx;
		logic [CNT_W-1:0] d;
		for (i = 0; i < 4; i++) begin
			idx = cfg_idx_t'(i);
			case (idx)
				CFG_PRESS_DB:   d = c.press_db;
				CFG_RELEASE_DB: d = c.release_db;
				CFG_PRESCALE:   d = c.prescale;
				default:        d = c.max_hold;
			endcase
			cfg_index <= idx;
			cfg_data  <= d;
			cfg_valid <= 1'b1;
			do
				@(posedge clk);
			while (!cfg_ready);
			case (idx)
				CFG_PRESS_DB:   kp_cfg.press_db   = d;
				CFG_RELEASE_DB: kp_cfg.release_db = d;
				CFG_PRESCALE:   kp_cfg.prescale   = d;
				default:        kp_cfg.max_hold   = d;
			endcase
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic report_failure(input string what, input answer_t want,
		input answer_t got);
		n_failures++;
		if (n_failures <= 10)
			$display("%s at %0t: want v=%0b k=%0d h=%0b, got v=%0b k=%0d h=%0b",
				what, $time, want.ev_valid, want.ev_key, want.held,
				got.ev_valid, got.ev_key, got.held);
	endtask

	// Reset values: empty read, zero threshold, idle key, spare op with every
	// field at its top value.
	task automatic test_reset_state();
		send_request(pack_request(OP_READ, 4'h0, 2'd0, 10'd0));
		send_request(pack_request(OP_QUERY, 4'h0, 2'd0, 10'd0));
		send_request(pack_request(OP_QUERY, 4'h0, 2'd3, 10'd1));
		send_request(pack_request(OP_SPARE, 4'hF, 2'd3, 10'h3FF));
		send_request(pack_request(OP_READ, 4'hF, 2'd3, 10'h3FF));
	endtask

	// Zero debounce and prescale: all keys confirm on one tick, the highest index
	// is reported, hold counts saturate, a second read comes back empty.
	task automatic test_press_confirm_and_hold();
		settle();
		load_config('{press_db: 10'd0, release_db: 10'd0, prescale: 10'd0,
			max_hold: 10'd3});
		send_request(pack_request(OP_TICK, 4'h0, 2'd3, 10'h3FF));
		repeat (5) send_request(pack_request(OP_TICK, 4'hF, 2'd0, 10'd0));
		send_request(pack_request(OP_QUERY, 4'h0, 2'd2, 10'd3));
		send_request(pack_request(OP_QUERY, 4'h0, 2'd1, 10'h3FF));
		send_request(pack_request(OP_READ, 4'h0, 2'd0, 10'd0));
		send_request(pack_request(OP_READ, 4'h0, 2'd0, 10'd0));
	endtask

	// Drop the limit below the held counts, then bounce key 3 through release
	// debounce and back to held, which must not raise a new event.
	task automatic test_lowered_limit_and_release_bounce();
		settle();
		load_config('{press_db: 10'd0, release_db: 10'd0, prescale: 10'd0,
			max_hold: 10'd1});
		send_request(pack_request(OP_TICK, 4'hF, 2'd0, 10'd0));
		send_request(pack_request(OP_QUERY, 4'h0, 2'd0, 10'd3));
		send_request(pack_request(OP_TICK, 4'h7, 2'd0, 10'd0));
		send_request(pack_request(OP_TICK, 4'hF, 2'd0, 10'd0));
		send_request(pack_request(OP_QUERY, 4'h0, 2'd3, 10'd1));
		send_request(pack_request(OP_TICK, 4'h0, 2'd0, 10'd0));
		send_request(pack_request(OP_TICK, 4'h0, 2'd0, 10'd0));
		send_request(pack_request(OP_READ, 4'h0, 2'd0, 10'd0));
	endtask

	task automatic run_random_phase(input cfg_t c, input int count);
		int i;
		settle();
		load_config(c);
		for (i = 0; i < count; i++) begin
			// switch idling on and off in stretches
			if (i % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			// hold the sender now and then until every result is back
			if (i % 137 == 136)
				settle();
			send_request(make_random_request());
		end
		no_idle = 1'b0;
	endtask

	// Short debounce and prescale so presses confirm and counts saturate often;
	// the first phase has debounce and prescale at zero, the last a hold limit of zero.
	task automatic test_random_small_timings();
		int   p;
		cfg_t c;
		run_random_phase('{press_db: 10'd0, release_db: 10'd0, prescale: 10'd0,
			max_hold: 10'h3FF}, PHASE_ITEMS);
		for (p = 0; p < 5; p++) begin
			c.press_db   = CNT_W'($urandom_range(0, 5));
			c.release_db = CNT_W'($urandom_range(0, 5));
			c.prescale   = CNT_W'($urandom_range(0, 3));
			c.max_hold   = CNT_W'($urandom_range(0, 8));
			run_random_phase(c, PHASE_ITEMS);
		end
		run_random_phase('{press_db: 10'd3, release_db: 10'd2, prescale: 10'd1,
			max_hold: 10'd0}, PHASE_ITEMS);
	endtask

	// Every register at its top value: nothing confirms, counters run long.
	task automatic test_random_extreme_registers();
		run_random_phase('{press_db: 10'h3FF, release_db: 10'h3FF, prescale: 10'h3FF,
			max_hold: 10'h3FF}, PHASE_ITEMS);
	endtask

	// Receiver: random stall runs, mostly short, a few long.
	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run--;
			out_stall <= 1'b1;
		end else if (no_idle) begin
			out_stall <= 1'b0;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 65) begin
				out_stall <= 1'b0;
			end else if (stall_pick < 95) begin
				stall_run = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				stall_run = $urandom_range(10, 40);
				out_stall <= 1'b1;
			end
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			got_ans.ev_valid = event_valid;
			got_ans.ev_key   = event_key;
			got_ans.held     = held_enough;
			if (answer_q.size() == 0) begin
				report_failure("Unexpected result", '0, got_ans);
			end else begin
				want_ans = answer_q.pop_front();
				if (got_ans.ev_valid !== want_ans.ev_valid
					|| got_ans.ev_key !== want_ans.ev_key
					|| got_ans.held !== want_ans.held)
					report_failure("Result mismatch", want_ans, got_ans);
			end
		end
	end

	// End the run if no handshake of any kind happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: %0d quiet cycles, %0d results outstanding",
					quiet_cycles, answer_q.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_press_confirm_and_hold();
		test_lowered_limit_and_release_bounce();
		test_random_small_timings();
		test_random_extreme_registers();
		settle();
		if (answer_q.size() != 0)
			n_failures += answer_q.size();
		$display("Sent %0d requests over %0d register settings; %0d reads found a press.",
			n_requests, n_settings, n_events);
		$display("Checked %0d results, %0d failures.", n_results, n_failures);
		if (n_failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
src/mkdh_pkg.sv
src/mkdh_key.sv
src/multi_key_debounce_hold_timer_unit.sv
src/mkdh_chk.sv
bench/tb.sv
